[src/rectangle_rasterizer_defines.svh]
// Assertion macros shared by the rectangle rasterizer RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef RECTANGLE_RASTERIZER_DEFINES_SVH
`define RECTANGLE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RR_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RR_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rrast_pkg.sv]
// Shared types and constants of the rectangle rasterizer.
// Depends on nothing; imported by every rasterizer module except rrast_ram.
`default_nettype none

package rrast_pkg;

    localparam int MAX_DIM_DEF   = 256;
    localparam int FRAC_BITS_DEF = 8;
    localparam int COORD_W       = 20;
    localparam int GRID_W        = 9;
    localparam int CHAR_W        = 8;
    localparam int MODE_W        = 2;
    localparam int IDX_W         = 8;
    localparam int CFG_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;
    localparam logic [GRID_W-1:0] GRID_RESET = 9'd256;
    localparam logic [CHAR_W-1:0] BG_RESET   = 8'd32;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 2'd0,
        MODE_DRAW  = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DRAW,
        ST_READ
    } state_t;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_BACKGROUND  = 2'd2
    } reg_idx_t;

    // Control of the coverage unit from the sequencer.
    typedef struct packed {
        logic load;   // capture a new rectangle
        logic step;   // advance one pixel
        logic wrap;   // current pixel closes its row
    } cover_ctl_t;

endpackage

`default_nettype wire

[src/rrast_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module rrast_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/rrast_cover.sv]
// Coverage unit: tracks pixel offsets from the rectangle corner and decides
// inside/outline coverage. Depends on rrast_pkg.
`default_nettype none

module rrast_cover
    import rrast_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire cover_ctl_t                ctl,
    input  wire logic                      rect_kind,
    input  wire logic signed [COORD_W-1:0] rect_left,
    input  wire logic signed [COORD_W-1:0] rect_top,
    input  wire logic signed [COORD_W-1:0] rect_w,
    input  wire logic signed [COORD_W-1:0] rect_h,
    output logic                           covered
);

    localparam int DIM_BITS = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int PXW      = DIM_BITS + FRAC_BITS;
    localparam int CW       = ((PXW + 1 > COORD_W) ? PXW + 1 : COORD_W) + 1;
    localparam logic signed [CW-1:0] ONE = CW'(64'd1 << FRAC_BITS);

    // Offsets of the current pixel from left/top edge, and extents
    logic signed [CW-1:0] dx_reg, dx_next;
    logic signed [CW-1:0] dy_reg, dy_next;
    logic signed [CW-1:0] nleft_reg;
    logic signed [CW-1:0] w_reg, h_reg, wm_reg, hm_reg;
    logic                 outline_reg;

    logic x_in, y_in, x_edge, y_edge;

    always_comb
    begin
        dx_next = dx_reg;
        dy_next = dy_reg;
        if (ctl.load)
        begin
            dx_next = -CW'(rect_left);
            dy_next = -CW'(rect_top);
        end
        else if (ctl.step)
        begin
            if (ctl.wrap)
            begin
                dx_next = nleft_reg;
                dy_next = dy_reg + ONE;
            end
            else
            begin
                dx_next = dx_reg + ONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        if (ctl.load)
        begin
            nleft_reg   <= -CW'(rect_left);
            w_reg       <= CW'(rect_w);
            h_reg       <= CW'(rect_h);
            wm_reg      <= CW'(rect_w) - ONE;
            hm_reg      <= CW'(rect_h) - ONE;
            outline_reg <= rect_kind;
        end
    end

    // Right-edge test: right - px < one  <=>  dx > w - one
    always_comb
    begin
        x_in    = (dx_reg >= 0) && (dx_reg <= w_reg);
        y_in    = (dy_reg >= 0) && (dy_reg <= h_reg);
        x_edge  = (dx_reg < ONE) || (dx_reg > wm_reg);
        y_edge  = (dy_reg < ONE) || (dy_reg > hm_reg);
        covered = x_in && y_in && (!outline_reg || x_edge || y_edge);
    end

endmodule

`default_nettype wire

[src/rrast_seq.sv]
// Sequencer: walks the frame store for clear and draw, runs reads, and
// forms the result strobe. Depends on rrast_pkg and the assertion macros.
`default_nettype none
`include "rectangle_rasterizer_defines.svh"

module rrast_seq
    import rrast_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      start,
    input  wire logic [MODE_W-1:0]                         mode,
    input  wire logic signed [COORD_W-1:0]                 rect_w,
    input  wire logic signed [COORD_W-1:0]                 rect_h,
    input  wire logic [CHAR_W-1:0]                         paint_char,
    input  wire logic [IDX_W-1:0]                          read_row,
    input  wire logic [IDX_W-1:0]                          read_col,
    input  wire logic [GRID_W-1:0]                         grid_width,
    input  wire logic [GRID_W-1:0]                         grid_height,
    input  wire logic [CHAR_W-1:0]                         background_char,
    input  wire logic                                      covered,
    input  wire logic [CHAR_W-1:0]                         mem_rdata,
    output logic                                           busy,
    output logic                                           done,
    output logic [CHAR_W-1:0]                              pixel_char,
    output logic                                           status,
    output cover_ctl_t                                     cover_ctl,
    output logic                                           mem_we,
    output logic [2*((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] mem_waddr,
    output logic [CHAR_W-1:0]                              mem_wdata,
    output logic [2*((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] mem_raddr
);

    localparam int DIM_BITS = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW       = 2 * DIM_BITS;
    localparam int CNT_BITS = $clog2(MAX_DIM + 1);
    localparam int EW       = (CNT_BITS > GRID_W) ? CNT_BITS : GRID_W;
    localparam logic [EW-1:0] MAX_E = EW'(MAX_DIM);

    state_t              state_reg, state_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic                done_reg, done_next;
    logic [CHAR_W-1:0]   pixel_reg, pixel_next;
    logic                status_reg, status_next;
    logic [CHAR_W-1:0]   paint_reg, paint_next;
    logic                inrange_reg, inrange_next;

    logic [EW-1:0]       cols_e, rows_e, gw_e, gh_e;
    logic [DIM_BITS-1:0] row_cur, col_cur;
    logic                last_col, last_row, clear_last;
    logic                accept, reject, read_ok;

    // Clamp the grid registers to 1..MAX_DIM
    always_comb
    begin
        gw_e   = EW'(grid_width);
        gh_e   = EW'(grid_height);
        cols_e = (gw_e == '0) ? EW'(1) : ((gw_e > MAX_E) ? MAX_E : gw_e);
        rows_e = (gh_e == '0) ? EW'(1) : ((gh_e > MAX_E) ? MAX_E : gh_e);
    end

    assign row_cur    = addr_reg[AW-1 -: DIM_BITS];
    assign col_cur    = addr_reg[DIM_BITS-1:0];
    assign last_col   = (EW'(col_cur) == cols_e - EW'(1));
    assign last_row   = (EW'(row_cur) == rows_e - EW'(1));
    assign clear_last = &addr_reg;
    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign reject     = rect_w[COORD_W-1] || (rect_w == '0) ||
                        rect_h[COORD_W-1] || (rect_h == '0);
    assign read_ok    = (EW'(read_row) < rows_e) && (EW'(read_col) < cols_e);

    // Next state and datapath registers
    always_comb
    begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        done_next    = 1'b0;
        pixel_next   = '0;
        status_next  = 1'b0;
        paint_next   = paint_reg;
        inrange_next = inrange_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                            addr_next  = '0;
                        end
                        MODE_DRAW:
                        begin
                            if (reject)
                            begin
                                done_next   = 1'b1;
                                status_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_DRAW;
                                addr_next  = '0;
                                paint_next = paint_char;
                            end
                        end
                        MODE_READ:
                        begin
                            state_next   = ST_READ;
                            inrange_next = read_ok;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                addr_next = addr_reg + AW'(1);
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            ST_DRAW:
            begin
                if (last_col)
                begin
                    addr_next = {row_cur + DIM_BITS'(1), {DIM_BITS{1'b0}}};
                    if (last_row)
                    begin
                        state_next = ST_IDLE;
                        done_next  = 1'b1;
                    end
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                pixel_next = inrange_reg ? mem_rdata : '0;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory and coverage-unit controls
    always_comb
    begin
        mem_we         = 1'b0;
        mem_wdata      = paint_reg;
        cover_ctl.load = accept && (mode == MODE_DRAW);
        cover_ctl.step = 1'b0;
        cover_ctl.wrap = last_col;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = background_char;
            end
            ST_DRAW:
            begin
                mem_we         = covered;
                cover_ctl.step = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign mem_waddr  = addr_reg;
    assign mem_raddr  = {DIM_BITS'(read_row), DIM_BITS'(read_col)};
    assign done       = done_reg;
    assign pixel_char = pixel_reg;
    assign status     = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        pixel_reg   <= pixel_next;
        status_reg  <= status_next;
        paint_reg   <= paint_next;
        inrange_reg <= inrange_next;
    end

    `RR_ASSERT_NEXT(a_read_done, clk, rst_n, state_reg == ST_READ, done_reg, "read gave no result")
    `RR_ASSERT_SAME(a_busy_end, clk, rst_n, $fell(busy), done_reg, "pass ended without result")
    `RR_ASSERT_SAME(a_idle_nowr, clk, rst_n, state_reg == ST_IDLE, !mem_we, "store write while idle")
    `RR_ASSERT_SAME(a_rej_pix, clk, rst_n, done_reg && status_reg, pixel_reg == '0, "reject with pixel")

endmodule

`default_nettype wire

[src/rectangle_rasterizer.sv]
// Rectangle rasterizer over a character frame buffer.
// Channels: start/busy request in, done strobe out; APB-style register port.
// A request is taken at a rising edge with start high and busy low. Modes:
//   clear - fills all 2**(2*clog2(MAX_DIM)) store entries with the background
//           character, one entry a cycle.
//   draw  - visits every pixel of the rows x cols grid once, one a cycle, and
//           paints the covered ones.
//           A non-positive width or height is rejected with status 1 and
//           never raises busy.
//   read  - addresses the store as the request is taken, then takes the registered data.
//   mode 3 does nothing.
// Every request gives one result: done is high for one cycle with pixel_char
// and status, in the cycle busy drops (or the cycle after the request if
// busy never rose). The next request may be taken in that same cycle.
// The pixel walk, store write port and coverage unit set the rate: one pixel
// per cycle. The receiver cannot stall; results must be taken when strobed.
// Reset restores the grid to 256 x 256 and the background to a space; the
// frame store is not cleared and holds nothing defined until a clear or draw.
// Registers: grid_width at 0x0, grid_height at 0x4, background_char at 0x8.
`default_nettype none

module rectangle_rasterizer
    import rrast_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // configuration port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [CFG_ADDR_W-1:0]     paddr,
    input  wire logic [APB_DATA_W-1:0]     pwdata,
    output logic      [APB_DATA_W-1:0]     prdata,
    output logic                           pready,
    // request channel
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [MODE_W-1:0]         mode,
    input  wire logic                      rect_kind,
    input  wire logic signed [COORD_W-1:0] rect_left,
    input  wire logic signed [COORD_W-1:0] rect_top,
    input  wire logic signed [COORD_W-1:0] rect_w,
    input  wire logic signed [COORD_W-1:0] rect_h,
    input  wire logic [CHAR_W-1:0]         paint_char,
    input  wire logic [IDX_W-1:0]          read_row,
    input  wire logic [IDX_W-1:0]          read_col,
    // result channel
    output logic                           done,
    output logic [CHAR_W-1:0]              pixel_char,
    output logic                           status
);

    localparam int DIM_BITS = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW       = 2 * DIM_BITS;
    localparam int DEPTH    = 2 ** AW;

    logic [GRID_W-1:0] grid_width_reg;
    logic [GRID_W-1:0] grid_height_reg;
    logic [CHAR_W-1:0] background_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    cover_ctl_t        cover_ctl;
    logic              covered;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic [CHAR_W-1:0] mem_rdata;

    // Register port: always ready, write on the access phase
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_RESET;
            grid_height_reg <= GRID_RESET;
            background_reg  <= BG_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[GRID_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[GRID_W-1:0];
                REG_BACKGROUND:  background_reg  <= pwdata[CHAR_W-1:0];
                default:         background_reg  <= background_reg;
            endcase
        end
    end

    // Read back the register under the address; holes read zero
    always_comb
    begin
        case (cfg_idx)
            REG_GRID_WIDTH:  prdata = APB_DATA_W'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = APB_DATA_W'(grid_height_reg);
            REG_BACKGROUND:  prdata = APB_DATA_W'(background_reg);
            default:         prdata = '0;
        endcase
    end

    // Pixel walk, request/result handling
    rrast_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .mode            (mode),
        .rect_w          (rect_w),
        .rect_h          (rect_h),
        .paint_char      (paint_char),
        .read_row        (read_row),
        .read_col        (read_col),
        .grid_width      (grid_width_reg),
        .grid_height     (grid_height_reg),
        .background_char (background_reg),
        .covered         (covered),
        .mem_rdata       (mem_rdata),
        .busy            (busy),
        .done            (done),
        .pixel_char      (pixel_char),
        .status          (status),
        .cover_ctl       (cover_ctl),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_raddr       (mem_raddr)
    );

    // Shared coverage test, stepped once per visited pixel
    rrast_cover #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_cover (
        .clk       (clk),
        .ctl       (cover_ctl),
        .rect_kind (rect_kind),
        .rect_left (rect_left),
        .rect_top  (rect_top),
        .rect_w    (rect_w),
        .rect_h    (rect_h),
        .covered   (covered)
    );

    // Frame store, addressed {row, col}
    rrast_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire
